/* rtl/rusp_pkg.sv */
`default_nettype none

package rusp_pkg;

   // Ring index width; the ring holds 1 << RingBits entries.
   localparam int RingBits    = 12;
   localparam int RingSize    = 1 << RingBits;
   localparam int MaxSpans    = 64;
   localparam int CountBits   = $clog2(MaxSpans + 1);
   localparam int OpBits      = 2;
   localparam int WrittenBits = 16;

   typedef logic [RingBits-1:0]  ring_idx_type;
   typedef logic [CountBits-1:0] count_type;

   typedef struct packed {
      logic         valid;
      ring_idx_type start;
      ring_idx_type size;
   } span_type;

   // Commands broadcast to every cell of the span chain.
   typedef enum logic [2:0] {
      CELL_HOLD  = 3'd0,
      CELL_PUSH  = 3'd1,
      CELL_POP   = 3'd2,
      CELL_EVICT = 3'd3,
      CELL_CLEAR = 3'd4
   } cell_cmd_type;

   typedef enum logic [OpBits-1:0] {
      OP_COMMIT   = 2'd0,
      OP_ROLLBACK = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NONE     = 2'd3
   } op_type;

endpackage

`default_nettype wire

/* rtl/rusp_cell.sv */
`default_nettype none

module rusp_cell import rusp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire span_type     fresh,
   input  wire span_type     left,
   input  wire span_type     right,
   output span_type          span,
   output logic              evict_hit
);

   span_type     span_ff;
   span_type     span_in;
   ring_idx_type fwd_dist;
   ring_idx_type back_dist;

   // Circular overlap test of the stored span against the incoming span.
   // Only the oldest valid cell (no valid neighbour on the older side) may hit.
   assign fwd_dist  = span_ff.start - fresh.start;
   assign back_dist = fresh.start - span_ff.start;
   assign evict_hit = span_ff.valid && !right.valid &&
                      ((fwd_dist < fresh.size) || (back_dist < span_ff.size));

   always_comb begin
      span_in = span_ff;
      unique case (cmd)
         CELL_HOLD:  span_in = span_ff;
         CELL_PUSH:  span_in = left;
         CELL_POP:   span_in = right;
         CELL_EVICT: if (evict_hit) span_in.valid = 1'b0;
         CELL_CLEAR: span_in.valid = 1'b0;
         default:    span_in = span_ff;
      endcase
   end

   // Only the valid bit needs a reset; the span data is ignored while invalid.
   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff.valid <= 1'b0;
      end else begin
         span_ff.valid <= span_in.valid;
      end
      span_ff.start <= span_in.start;
      span_ff.size  <= span_in.size;
   end

   assign span = span_ff;

endmodule

`default_nettype wire

/* rtl/rusp_chain.sv */
`default_nettype none

module rusp_chain import rusp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_cmd_type cmd,
   input  wire span_type     fresh,
   output span_type          newest,
   output logic              any_evict
);

   // Cell 0 holds the newest span, older spans sit further down the row.
   span_type              spans [MaxSpans];
   logic [MaxSpans-1:0]   hits;

   for (genvar i = 0; i < MaxSpans; i++) begin : g_cell
      span_type left_span;
      span_type right_span;

      if (i == 0) begin : g_first
         assign left_span = fresh;
      end else begin : g_mid_left
         assign left_span = spans[i-1];
      end

      if (i == MaxSpans - 1) begin : g_last
         assign right_span = '0;
      end else begin : g_mid_right
         assign right_span = spans[i+1];
      end

      rusp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .fresh     (fresh),
         .left      (left_span),
         .right     (right_span),
         .span      (spans[i]),
         .evict_hit (hits[i])
      );
   end

   assign newest    = spans[0];
   assign any_evict = |hits;

endmodule

`default_nettype wire

/* rtl/ring_undo_span_tracker_core.sv */
`default_nettype none

// Channel    Direction  Handshake              Payload
// req_       in         req_valid / req_ready  operation, entry_count
// rsp_       out        rsp_valid / rsp_ready  span_found, span_start, span_size,
//                                              evicted_count, overflow,
//                                              spans_stored, next_head
//
// Rollback, clear, unused-code, overflow and zero-count transactions go from
// acceptance straight to the final state, which loads the output register.
// A normal commit first passes the evict state, which drops the k (at most 64)
// spans that overlap the new one, one per cycle, and then the push state. A new
// transaction is taken while a result still waits in the output register; a
// second result stalls the sequencer in its final state until the first is taken.
// Reset clears the sequencer, counters and all cell valid bits.

module ring_undo_span_tracker_core import rusp_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [OpBits-1:0]      req_operation,
   input  wire logic [WrittenBits-1:0] req_entry_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_span_found,
   output logic [RingBits-1:0]         rsp_span_start,
   output logic [RingBits-1:0]         rsp_span_size,
   output logic [CountBits-1:0]        rsp_evicted_count,
   output logic                        rsp_overflow,
   output logic [CountBits-1:0]        rsp_spans_stored,
   output logic [RingBits-1:0]         rsp_next_head
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVICT  = 4'b0010,
      ST_PUSH   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   ring_idx_type head_ff, head_in;
   ring_idx_type fresh_start_ff, fresh_start_in;
   ring_idx_type fresh_size_ff, fresh_size_in;

   // Result fields staged while the transaction is in work.
   logic         found_ff, found_in;
   ring_idx_type rstart_ff, rstart_in;
   ring_idx_type rsize_ff, rsize_in;
   count_type    evicted_ff, evicted_in;
   logic         ovf_ff, ovf_in;

   // Output register.
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_found_ff;
   ring_idx_type rsp_start_ff, rsp_size_ff, rsp_head_ff;
   count_type    rsp_evicted_ff, rsp_stored_ff;
   logic         rsp_ovf_ff;

   cell_cmd_type cmd;
   span_type     fresh;
   span_type     newest;
   logic         any_evict;
   logic         req_take;
   logic         rsp_load;
   op_type       op;
   count_type    count_dec;

   assign op        = op_type'(req_operation);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   assign count_dec = count_ff - count_type'(1);

   // The fresh span always comes from the registered copy taken at acceptance;
   // the chain only looks at it while evicting and pushing.
   always_comb begin
      fresh.valid = 1'b1;
      fresh.start = fresh_start_ff;
      fresh.size  = fresh_size_ff;
   end

   rusp_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .fresh     (fresh),
      .newest    (newest),
      .any_evict (any_evict)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      head_in        = head_ff;
      fresh_start_in = fresh_start_ff;
      fresh_size_in  = fresh_size_ff;
      found_in       = found_ff;
      rstart_in      = rstart_ff;
      rsize_in       = rsize_ff;
      evicted_in     = evicted_ff;
      ovf_in         = ovf_ff;
      cmd            = CELL_HOLD;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               found_in   = 1'b0;
               rstart_in  = '0;
               rsize_in   = '0;
               evicted_in = '0;
               ovf_in     = 1'b0;
               state_in   = ST_FINISH;
               unique case (op)
                  OP_COMMIT: begin
                     if (req_entry_count > WrittenBits'(RingSize - 1)) begin
                        // Overflow: the whole history is invalid.
                        evicted_in = count_ff;
                        ovf_in     = 1'b1;
                        count_in   = '0;
                        head_in    = '0;
                        cmd        = CELL_CLEAR;
                     end else if (req_entry_count != '0) begin
                        fresh_start_in = head_ff;
                        fresh_size_in  = req_entry_count[RingBits-1:0];
                        head_in        = head_ff + req_entry_count[RingBits-1:0];
                        state_in       = ST_EVICT;
                     end
                  end
                  OP_ROLLBACK: begin
                     if (count_ff != '0) begin
                        found_in  = 1'b1;
                        rstart_in = newest.start;
                        rsize_in  = newest.size;
                        count_in  = count_dec;
                        head_in   = (count_dec != '0) ? newest.start : '0;
                        cmd       = CELL_POP;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     cmd      = CELL_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_EVICT: begin
            // One overlapping oldest span leaves per cycle.
            if (any_evict) begin
               cmd        = CELL_EVICT;
               count_in   = count_dec;
               evicted_in = evicted_ff + count_type'(1);
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            // The shift drops the oldest span on its own when the row is full.
            cmd = CELL_PUSH;
            if (count_ff == count_type'(MaxSpans)) begin
               evicted_in = evicted_ff + count_type'(1);
            end else begin
               count_in = count_ff + count_type'(1);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fresh_start_ff <= fresh_start_in;
      fresh_size_ff  <= fresh_size_in;
      found_ff       <= found_in;
      rstart_ff      <= rstart_in;
      rsize_ff       <= rsize_in;
      evicted_ff     <= evicted_in;
      ovf_ff         <= ovf_in;
      if (rsp_load) begin
         rsp_found_ff   <= found_ff;
         rsp_start_ff   <= rstart_ff;
         rsp_size_ff    <= rsize_ff;
         rsp_evicted_ff <= evicted_ff;
         rsp_ovf_ff     <= ovf_ff;
         rsp_stored_ff  <= count_ff;
         rsp_head_ff    <= head_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_span_found    = rsp_found_ff;
   assign rsp_span_start    = rsp_start_ff;
   assign rsp_span_size     = rsp_size_ff;
   assign rsp_evicted_count = rsp_evicted_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_spans_stored  = rsp_stored_ff;
   assign rsp_next_head     = rsp_head_ff;

`ifndef NO_ASSERTIONS
   // The span counter never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(MaxSpans))
      else $error("span count above capacity");

   // The newest cell holds a span exactly when the counter is non-zero.
   a_chain_matches_count: assert property (@(posedge clock) disable iff (reset)
      newest.valid == (count_ff != '0))
      else $error("span chain and counter disagree");

   // An eviction hit can only come from a non-empty queue.
   a_evict_needs_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVICT) && any_evict |-> count_ff != '0)
      else $error("eviction with empty queue");

   // An overflow result reports an empty queue and a head at zero.
   a_overflow_empties: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_spans_stored == '0 && rsp_next_head == '0)
      else $error("overflow result not empty");

   // A rollback result never reports evictions or overflow.
   a_rollback_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_span_found |-> rsp_evicted_count == '0 && !rsp_overflow)
      else $error("rollback result mixes commit fields");
`endif

endmodule

`default_nettype wire

/* bench/ring_undo_span_tracker_core_tb.sv */
`timescale 1ns / 1ps

module ring_undo_span_tracker_core_tb import rusp_pkg::*;;

   // The run is ended by force after this many clock cycles. The slowest
   // correct run is far shorter: about two thousand transactions, each with
   // random idle gaps on either side and its work in the block, plus the
   // long receiver hold-off.
   localparam int unsigned CycleLimit  = 1_000_000;
   // Cycles allowed after the last report for anything stray to show up.
   // A commit that evicts every span is the longest transaction.
   localparam int unsigned DrainCycles = 100;
   localparam int unsigned RandomItems = 1700;
   localparam int unsigned HoldOffCycles = 400;

   // One report of the block, as it appears on the rsp_ channel.
   typedef struct {
      logic         span_found;
      ring_idx_type span_start;
      ring_idx_type span_size;
      count_type    evicted_count;
      logic         overflow;
      count_type    spans_stored;
      ring_idx_type next_head;
   } span_report_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [OpBits-1:0]      req_operation;
   logic [WrittenBits-1:0] req_entry_count;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_span_found;
   logic [RingBits-1:0]    rsp_span_start;
   logic [RingBits-1:0]    rsp_span_size;
   logic [CountBits-1:0]   rsp_evicted_count;
   logic                   rsp_overflow;
   logic [CountBits-1:0]   rsp_spans_stored;
   logic [RingBits-1:0]    rsp_next_head;

   // Reports still owed by the block, oldest first.
   span_report_type pending_reports[$];

   // Our own copy of the journal: a circular queue of spans plus the head.
   ring_idx_type journal_start[MaxSpans];
   ring_idx_type journal_size[MaxSpans];
   int unsigned  oldest_slot;
   int unsigned  span_count;
   ring_idx_type write_head;

   int unsigned  error_count;
   int unsigned  commands_sent;
   int unsigned  cycle_count;
   // Cleared for stretches in which neither side inserts idle cycles.
   bit           idle_enabled;
   // Set by the stimulus to make the receiver hold off for that many cycles.
   int unsigned  hold_off_request;

   ring_undo_span_tracker_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_count   (req_entry_count),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_span_found    (rsp_span_found),
      .rsp_span_start    (rsp_span_start),
      .rsp_span_size     (rsp_span_size),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_overflow      (rsp_overflow),
      .rsp_spans_stored  (rsp_spans_stored),
      .rsp_next_head     (rsp_next_head)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: a hung handshake must not keep the run going for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Two spans overlap on the circle when either start lies inside the
   // other span. The 12-bit differences wrap exactly as the ring does.
   function automatic bit spans_collide(ring_idx_type s, ring_idx_type n,
                                        ring_idx_type t, ring_idx_type m);
      ring_idx_type t_from_s;
      ring_idx_type s_from_t;
      t_from_s = t - s;
      s_from_t = s - t;
      return (t_from_s < n) || (s_from_t < m);
   endfunction

   // Applies one command to our copy of the journal and returns the report
   // that the block must give for it.
   function automatic span_report_type track_span_journal(op_type op,
                                                          logic [WrittenBits-1:0] written);
      span_report_type report;
      ring_idx_type    fresh_start;
      ring_idx_type    fresh_size;
      int unsigned     slot;
      int unsigned     evicted;
      report  = '{default: '0};
      evicted = 0;
      case (op)
         OP_COMMIT: begin
            if (written > RingSize - 1) begin
               // The count ran past the whole ring, so no history survives.
               evicted     = span_count;
               span_count  = 0;
               oldest_slot = 0;
               write_head  = '0;
               report.overflow = 1'b1;
            end else if (written != 0) begin
               fresh_start = write_head;
               fresh_size  = written[RingBits-1:0];
               write_head  = fresh_start + fresh_size;
               // Drop the oldest spans for as long as the new one lands on them.
               while (span_count > 0 &&
                      spans_collide(fresh_start, fresh_size,
                                    journal_start[oldest_slot],
                                    journal_size[oldest_slot])) begin
                  oldest_slot = (oldest_slot + 1) % MaxSpans;
                  span_count--;
                  evicted++;
               end
               // A full queue loses its oldest span to make room.
               if (span_count >= MaxSpans) begin
                  oldest_slot = (oldest_slot + 1) % MaxSpans;
                  span_count--;
                  evicted++;
               end
               slot = (oldest_slot + span_count) % MaxSpans;
               journal_start[slot] = fresh_start;
               journal_size[slot]  = fresh_size;
               span_count++;
            end
         end
         OP_ROLLBACK: begin
            if (span_count > 0) begin
               slot = (oldest_slot + span_count - 1) % MaxSpans;
               span_count--;
               report.span_found = 1'b1;
               report.span_start = journal_start[slot];
               report.span_size  = journal_size[slot];
               write_head = (span_count > 0) ? journal_start[slot] : '0;
            end
         end
         OP_CLEAR: begin
            span_count  = 0;
            oldest_slot = 0;
         end
         default: begin
         end
      endcase
      report.evicted_count = count_type'(evicted);
      report.spans_stored  = count_type'(span_count);
      report.next_head     = write_head;
      return report;
   endfunction

   // Offers one command on the req_ channel after a random number of idle
   // cycles, and records the expected report once the block has taken it.
   task automatic send_command(op_type op, logic [WrittenBits-1:0] written);
      int unsigned gap;
      gap = idle_enabled ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_entry_count <= written;
      do @(posedge clock); while (!req_ready);
      pending_reports.insert(pending_reports.size(), track_span_journal(op, written));
      commands_sent++;
   endtask

   // Receiver: waits a random number of cycles before each transaction and,
   // when asked, holds off for a long stretch so that the block backs up.
   initial begin
      int unsigned gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_request > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off_request) @(negedge clock);
            hold_off_request = 0;
         end
         gap = idle_enabled ? $urandom_range(0, 7) : 0;
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Every report taken from the block is checked against the oldest one
   // that is still owed, field by field.
   always @(posedge clock) begin
      span_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            $error("Report transaction arrived with none outstanding");
            error_count++;
         end else begin
            want = pending_reports[0];
            pending_reports.delete(0);
            if (rsp_span_found !== want.span_found) begin
               $error("span_found: expected %0d, actual %0d", want.span_found,
                      rsp_span_found);
               error_count++;
            end
            if (rsp_span_start !== want.span_start) begin
               $error("span_start: expected %0d, actual %0d", want.span_start,
                      rsp_span_start);
               error_count++;
            end
            if (rsp_span_size !== want.span_size) begin
               $error("span_size: expected %0d, actual %0d", want.span_size,
                      rsp_span_size);
               error_count++;
            end
            if (rsp_evicted_count !== want.evicted_count) begin
               $error("evicted_count: expected %0d, actual %0d", want.evicted_count,
                      rsp_evicted_count);
               error_count++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %0d, actual %0d", want.overflow,
                      rsp_overflow);
               error_count++;
            end
            if (rsp_spans_stored !== want.spans_stored) begin
               $error("spans_stored: expected %0d, actual %0d", want.spans_stored,
                      rsp_spans_stored);
               error_count++;
            end
            if (rsp_next_head !== want.next_head) begin
               $error("next_head: expected %0d, actual %0d", want.next_head,
                      rsp_next_head);
               error_count++;
            end
         end
      end
   end

   // Hand-picked commands: empty-queue rollback and clear, the unused code,
   // zero and overflowing counts, the largest legal span, wrap past the end
   // of the ring and a commit that lands exactly on an older span.
   task automatic test_directed_edges();
      send_command(OP_ROLLBACK, 16'h0000);
      send_command(OP_CLEAR,    16'hFFFF);
      send_command(OP_NONE,     16'hFFFF);
      send_command(OP_COMMIT,   16'd0);
      send_command(OP_COMMIT,   16'd1);
      send_command(OP_COMMIT,   16'd4095);
      send_command(OP_COMMIT,   16'd1);
      send_command(OP_ROLLBACK, 16'h1234);
      send_command(OP_ROLLBACK, 16'h0000);
      send_command(OP_ROLLBACK, 16'hFFFF);
      send_command(OP_COMMIT,   16'd4000);
      send_command(OP_COMMIT,   16'd200);
      send_command(OP_ROLLBACK, 16'h0000);
      send_command(OP_COMMIT,   16'd4096);
      send_command(OP_COMMIT,   16'd65535);
      send_command(OP_COMMIT,   16'd10);
      send_command(OP_COMMIT,   16'd20);
      send_command(OP_CLEAR,    16'h0000);
      send_command(OP_ROLLBACK, 16'h0000);
      send_command(OP_COMMIT,   16'h8001);
      send_command(OP_COMMIT,   16'h0AAA);
      send_command(OP_COMMIT,   16'h0555);
      send_command(OP_NONE,     16'h0000);
      send_command(OP_ROLLBACK, 16'h5555);
   endtask

   // Fills the queue with short spans that never overlap, so that the oldest
   // span is dropped for want of room, then unwinds part of it.
   task automatic test_full_queue();
      int unsigned fills;
      int unsigned undo;
      fills = $urandom_range(MaxSpans, MaxSpans + 8);
      repeat (fills) send_command(OP_COMMIT, 16'($urandom_range(1, 40)));
      undo = $urandom_range(0, 10);
      repeat (undo) send_command(OP_ROLLBACK, 16'($urandom));
   endtask

   // Mostly well-formed histories: runs of commits with random sizes and a
   // few undos, with overflows, clears, long unwinds and noise mixed in.
   task automatic test_random_histories();
      int unsigned episode;
      int unsigned run;
      while (commands_sent < RandomItems) begin
         episode = $urandom_range(0, 9);
         case (episode)
            0, 1, 2, 3, 4: begin
               run = $urandom_range(1, 20);
               repeat (run) begin
                  // Small spans keep many entries alive; an occasional large
                  // one sweeps a long run of them out in a single commit.
                  if ($urandom_range(0, 15) == 0)
                     send_command(OP_COMMIT, 16'($urandom_range(1500, RingSize - 1)));
                  else
                     send_command(OP_COMMIT, 16'($urandom_range(1, 150)));
               end
               run = $urandom_range(0, 5);
               repeat (run) send_command(OP_ROLLBACK, 16'($urandom));
            end
            5: begin
               run = $urandom_range(1, 12);
               repeat (run) send_command(OP_ROLLBACK, 16'($urandom));
            end
            6: test_full_queue();
            7: send_command(op_type'($urandom_range(0, 3)), 16'($urandom));
            8: begin
               if ($urandom_range(0, 1) == 0)
                  send_command(OP_COMMIT, 16'($urandom_range(RingSize, 65535)));
               else
                  send_command(OP_CLEAR, 16'($urandom));
            end
            default: begin
               if ($urandom_range(0, 1) == 0)
                  send_command(OP_COMMIT, 16'd0);
               else
                  send_command(OP_NONE, 16'($urandom));
            end
         endcase
      end
   endtask

   // The receiver holds off for a long stretch while commands keep coming,
   // so the output register and the work stage fill and req_ready drops.
   task automatic test_report_backpressure();
      int unsigned k;
      hold_off_request = HoldOffCycles;
      for (k = 0; k < 24; k++) begin
         if (k % 4 == 3)
            send_command(OP_ROLLBACK, 16'($urandom));
         else
            send_command(OP_COMMIT, 16'($urandom_range(1, 300)));
      end
   endtask

   // Back-to-back transactions on both sides with no idle cycles at all.
   task automatic test_back_to_back();
      idle_enabled = 1'b0;
      repeat (100) begin
         case ($urandom_range(0, 3))
            0:       send_command(OP_ROLLBACK, 16'($urandom));
            1:       send_command(op_type'($urandom_range(0, 3)), 16'($urandom));
            default: send_command(OP_COMMIT, 16'($urandom_range(1, 100)));
         endcase
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_operation    = OP_COMMIT;
      req_entry_count  = '0;
      error_count      = 0;
      commands_sent    = 0;
      cycle_count      = 0;
      idle_enabled     = 1'b1;
      hold_off_request = 0;
      oldest_slot      = 0;
      span_count       = 0;
      write_head       = '0;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_random_histories();
      test_report_backpressure();
      test_back_to_back();

      @(negedge clock);
      req_valid <= 1'b0;

      // Let every owed report come back, then give the block time to show
      // any report that it should not have produced.
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
